@@ rtl/asc_pkg.sv @@
// asc_pkg: operation codes, field widths, register map and the tag carried down the cell chain.
// No dependencies; every other file in rtl/ imports this package.
package asc_pkg;

   typedef enum logic [1:0] {
      OP_CMD_TO_SYS = 2'd0,
      OP_SYS_TO_CMD = 2'd1,
      OP_DISTANCE   = 2'd2
   } op_type;

   localparam int TYPE_W     = 2;
   localparam int CMD_W      = 16;
   localparam int SYS_W      = 20;
   localparam int DIST_W     = 21;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int MOD_W      = 16;

   // one turn and half a turn in 1/128 degree
   localparam logic [MOD_W-1:0] CMD_TURN = 16'd46080;
   localparam logic [MOD_W-1:0] CMD_HALF = 16'd23040;

   localparam logic [SYS_W-1:0] FULL_TURN_RESET  = 20'd524287;
   localparam logic [SYS_W-1:0] SCALE_CORR_RESET = 20'd0;

   // register select, taken from byte address bit 2
   localparam logic REG_FULL_TURN  = 1'b0;
   localparam logic REG_SCALE_CORR = 1'b1;

   typedef struct packed {
      op_type                   op;
      logic signed [DIST_W-1:0] span;
   } tag_type;

endpackage

@@ rtl/asc_if.sv @@
// asc_req_if / asc_rsp_if: valid-ready channels for request and result items.
// Depends on asc_pkg for the field widths.
interface asc_req_if import asc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [TYPE_W-1:0]       req_type;
   logic signed [CMD_W-1:0] cmd_angle;
   logic [SYS_W-1:0]        sys_angle;
   logic [SYS_W-1:0]        stop_angle;

   modport source (output valid, req_type, cmd_angle, sys_angle, stop_angle, input ready);
   modport sink   (input valid, req_type, cmd_angle, sys_angle, stop_angle, output ready);
endinterface

interface asc_rsp_if import asc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [SYS_W-1:0]         sys_result;
   logic signed [CMD_W-1:0]  cmd_result;
   logic signed [DIST_W-1:0] distance;

   modport source (output valid, sys_result, cmd_result, distance, input ready);
   modport sink   (input valid, sys_result, cmd_result, distance, output ready);
endinterface

@@ rtl/asc_front.sv @@
// asc_front: entry stage. Wraps the command angle, removes the correction, forms the
// dividend with one multiplier and works out the shortest distance. Depends on asc_pkg.
module asc_front import asc_pkg::*; #(
   parameter int ANGLE_BITS = 20,
   localparam int VW = (ANGLE_BITS < SYS_W) ? ANGLE_BITS : SYS_W,
   localparam int MW = (ANGLE_BITS > MOD_W) ? ANGLE_BITS : MOD_W,
   localparam int DW = (VW > MOD_W) ? VW : MOD_W,
   localparam int NW = ANGLE_BITS + MOD_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    src_valid,
   output logic                    src_ready,
   input  op_type                  src_op,
   input  logic signed [CMD_W-1:0] src_cmd,
   input  logic [SYS_W-1:0]        src_sys,
   input  logic [SYS_W-1:0]        src_stop,
   input  logic [SYS_W-1:0]        full_turn,
   input  logic [SYS_W-1:0]        scale_corr,
   input  logic                    dst_ready,
   output logic                    dst_valid,
   output logic [NW-1:0]           dst_n,
   output logic [DW-1:0]           dst_d,
   output tag_type                 dst_tag
);

   localparam int SW = VW + 2;

   logic [VW-1:0]         ft_m, corr_m, sys_m, stop_m;
   logic [MOD_W-1:0]      cmd_wrap;
   logic [ANGLE_BITS-1:0] rel;
   logic [MW-1:0]         mul_a;
   logic [DW-1:0]         mul_b;
   logic [MW+DW-1:0]      product;
   logic signed [SW-1:0]  a_s, b_s, ft_s, cw, ccw, cw_abs, ccw_abs, short_way;

   logic          valid_ff, valid_in;
   logic [NW-1:0] n_ff, n_in;
   logic [DW-1:0] d_ff, d_in;
   tag_type       tag_ff, tag_in;

   assign ft_m   = full_turn[VW-1:0];
   assign corr_m = scale_corr[VW-1:0];
   assign sys_m  = src_sys[VW-1:0];
   assign stop_m = src_stop[VW-1:0];

   // negative commands get a full turn added; the sum fits 16 bits
   assign cmd_wrap = src_cmd[CMD_W-1] ? ($unsigned(src_cmd) + CMD_TURN) : $unsigned(src_cmd);

   // correction removed modulo full turn, wrapped to the angle width
   assign rel = (sys_m >= corr_m) ? ANGLE_BITS'(sys_m - corr_m)
                : ANGLE_BITS'(ANGLE_BITS'(ft_m) + ANGLE_BITS'(sys_m) - ANGLE_BITS'(corr_m));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      d_in  = DW'(1);
      case (src_op)
         OP_CMD_TO_SYS: begin
            mul_a = MW'(cmd_wrap);
            mul_b = DW'(ft_m);
            d_in  = DW'(CMD_TURN);
         end
         OP_SYS_TO_CMD: begin
            mul_a = MW'(rel);
            mul_b = DW'(CMD_TURN);
            d_in  = DW'(ft_m);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
            d_in  = DW'(1);
         end
      endcase
   end

   assign product = mul_a * mul_b;
   assign n_in    = NW'(product);

   // shortest distance; ties go counterclockwise
   always_comb begin
      a_s  = $signed({2'b00, sys_m});
      b_s  = $signed({2'b00, stop_m});
      ft_s = $signed({2'b00, ft_m});
      if (b_s > a_s) begin
         cw  = b_s - a_s;
         ccw = cw - ft_s;
      end else begin
         ccw = b_s - a_s;
         cw  = ft_s + ccw;
      end
      cw_abs    = cw[SW-1] ? -cw : cw;
      ccw_abs   = ccw[SW-1] ? -ccw : ccw;
      short_way = (cw_abs < ccw_abs) ? cw : ccw;
   end

   assign tag_in.op   = src_op;
   assign tag_in.span = DIST_W'(short_way);
   assign valid_in    = src_valid;

   assign src_ready = !valid_ff || dst_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (src_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (src_ready && src_valid) begin
         n_ff   <= n_in;
         d_ff   <= d_in;
         tag_ff <= tag_in;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_n     = n_ff;
   assign dst_d     = d_ff;
   assign dst_tag   = tag_ff;

endmodule

@@ rtl/asc_cell.sv @@
// asc_cell: one restoring division step plus one step of the quotient-mod-turn reduction.
// Identical cells are chained; depends on asc_pkg.
module asc_cell import asc_pkg::*; #(
   parameter int NW = 36,
   parameter int DW = 20,
   parameter int QW = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             src_valid,
   output logic             src_ready,
   input  logic [NW-1:0]    src_n,
   input  logic [DW-1:0]    src_d,
   input  logic [DW-1:0]    src_r,
   input  logic [QW-1:0]    src_q,
   input  logic [MOD_W-1:0] src_m,
   input  tag_type          src_tag,
   input  logic             dst_ready,
   output logic             dst_valid,
   output logic [NW-1:0]    dst_n,
   output logic [DW-1:0]    dst_d,
   output logic [DW-1:0]    dst_r,
   output logic [QW-1:0]    dst_q,
   output logic [MOD_W-1:0] dst_m,
   output tag_type          dst_tag
);

   logic [DW:0]    trial;
   logic           fits;
   logic [MOD_W:0] mod_trial;

   logic             valid_ff, valid_in;
   logic [NW-1:0]    n_ff, n_in;
   logic [DW-1:0]    d_ff;
   logic [DW-1:0]    r_ff, r_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [MOD_W-1:0] m_ff, m_in;
   tag_type          tag_ff;

   assign trial = {src_r, src_n[NW-1]};
   assign fits  = trial >= {1'b0, src_d};
   assign r_in  = fits ? DW'(trial - {1'b0, src_d}) : DW'(trial);
   assign n_in  = {src_n[NW-2:0], 1'b0};
   assign q_in  = {src_q[QW-2:0], fits};

   // quotient bits arrive MSB first: m = (2m + bit) mod turn
   assign mod_trial = {src_m, fits};
   assign m_in = (mod_trial >= {1'b0, CMD_TURN}) ? MOD_W'(mod_trial - {1'b0, CMD_TURN})
                 : MOD_W'(mod_trial);

   assign valid_in  = src_valid;
   assign src_ready = !valid_ff || dst_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (src_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (src_ready && src_valid) begin
         n_ff   <= n_in;
         d_ff   <= src_d;
         r_ff   <= r_in;
         q_ff   <= q_in;
         m_ff   <= m_in;
         tag_ff <= src_tag;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_n     = n_ff;
   assign dst_d     = d_ff;
   assign dst_r     = r_ff;
   assign dst_q     = q_ff;
   assign dst_m     = m_ff;
   assign dst_tag   = tag_ff;

endmodule

@@ rtl/asc_back.sv @@
// asc_back: final stage. Adds the correction, maps the reduced quotient to a signed angle,
// selects the fields by operation and holds the result item. Depends on asc_pkg.
module asc_back import asc_pkg::*; #(
   parameter int ANGLE_BITS = 20,
   localparam int VW = (ANGLE_BITS < SYS_W) ? ANGLE_BITS : SYS_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     src_valid,
   output logic                     src_ready,
   input  logic [VW-1:0]            src_q,
   input  logic [MOD_W-1:0]         src_m,
   input  tag_type                  src_tag,
   input  logic [SYS_W-1:0]         full_turn,
   input  logic [SYS_W-1:0]         scale_corr,
   input  logic                     dst_ready,
   output logic                     dst_valid,
   output logic [SYS_W-1:0]         sys_result,
   output logic signed [CMD_W-1:0]  cmd_result,
   output logic signed [DIST_W-1:0] distance
);

   logic [VW-1:0]    ft_m, corr_m;
   logic [VW:0]      sum, sum_fix;
   logic [CMD_W-1:0] cmd_map;

   logic              valid_ff, valid_in;
   logic [SYS_W-1:0]  sys_ff, sys_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [DIST_W-1:0] dist_ff, dist_in;

   assign ft_m   = full_turn[VW-1:0];
   assign corr_m = scale_corr[VW-1:0];

   // reduced only when strictly above a full turn
   assign sum     = {1'b0, src_q} + {1'b0, corr_m};
   assign sum_fix = (sum > {1'b0, ft_m}) ? (sum - {1'b0, ft_m}) : sum;

   assign cmd_map = (src_m >= CMD_HALF) ? (src_m - CMD_TURN) : src_m;

   always_comb begin
      sys_in  = '0;
      cmd_in  = '0;
      dist_in = '0;
      case (src_tag.op)
         OP_CMD_TO_SYS: sys_in  = SYS_W'(sum_fix[VW-1:0]);
         OP_SYS_TO_CMD: cmd_in  = (ft_m == '0) ? '0 : cmd_map;
         OP_DISTANCE:   dist_in = src_tag.span;
         default: begin
            sys_in  = '0;
            cmd_in  = '0;
            dist_in = '0;
         end
      endcase
   end

   assign valid_in  = src_valid;
   assign src_ready = !valid_ff || dst_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (src_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (src_ready && src_valid) begin
         sys_ff  <= sys_in;
         cmd_ff  <= cmd_in;
         dist_ff <= dist_in;
      end
   end

   assign dst_valid  = valid_ff;
   assign sys_result = sys_ff;
   assign cmd_result = $signed(cmd_ff);
   assign distance   = $signed(dist_ff);

endmodule

@@ rtl/angle_scale_converter.sv @@
// angle_scale_converter: command/sensor angle conversion and shortest distance, top level.
// Depends on asc_pkg, asc_if (channels), asc_front, asc_cell and asc_back.
//
//   port     dir   kind             carries
//   req_ch   in    valid/ready      req_type, cmd_angle, sys_angle, stop_angle
//   rsp_ch   out   valid/ready      sys_result, cmd_result, distance
//   csr_*    in    APB-style        full_turn @ 0x0, scale_correction @ 0x4
//
// One item per cycle sustained while rsp_ch accepts results; the pipeline is the chain of
// ANGLE_BITS + 16 division cells, one quotient bit per cell, plus the entry multiply
// stage and the output register.
// Synchronous active-high reset empties the pipeline and loads the register defaults.
// Each stage holds its item while the one after it is full and stalled, so bubbles
// close up and items keep entering while a result waits at rsp_ch, until every stage is full.
module angle_scale_converter import asc_pkg::*; #(
   parameter int ANGLE_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   asc_req_if.sink               req_ch,
   asc_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // value width after masking (also the quotient width), divisor width, dividend width
   localparam int VW = (ANGLE_BITS < SYS_W) ? ANGLE_BITS : SYS_W;
   localparam int DW = (VW > MOD_W) ? VW : MOD_W;
   localparam int NW = ANGLE_BITS + MOD_W;

   // ---------------- configuration registers ----------------
   logic             csr_wr;
   logic [SYS_W-1:0] full_turn_ff, full_turn_in;
   logic [SYS_W-1:0] scale_corr_ff, scale_corr_in;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // bit 2 picks the word; byte-lane bits are ignored
   always_comb begin
      full_turn_in  = full_turn_ff;
      scale_corr_in = scale_corr_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_FULL_TURN:  full_turn_in  = csr_pwdata[SYS_W-1:0];
            REG_SCALE_CORR: scale_corr_in = csr_pwdata[SYS_W-1:0];
            default: begin
               full_turn_in  = full_turn_ff;
               scale_corr_in = scale_corr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_turn_ff  <= FULL_TURN_RESET;
         scale_corr_ff <= SCALE_CORR_RESET;
      end else begin
         full_turn_ff  <= full_turn_in;
         scale_corr_ff <= scale_corr_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_FULL_TURN:  csr_prdata = CSR_DATA_W'(full_turn_ff);
         REG_SCALE_CORR: csr_prdata = CSR_DATA_W'(scale_corr_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------- datapath ----------------
   // boundary k feeds cell k; boundary NW feeds the output stage
   logic             valid_w [0:NW];
   logic             ready_w [0:NW];
   logic [NW-1:0]    n_w     [0:NW-1];
   logic [DW-1:0]    d_w     [0:NW-1];
   logic [DW-1:0]    r_w     [0:NW-1];
   logic [VW-1:0]    q_w     [0:NW];
   logic [MOD_W-1:0] m_w     [0:NW];
   tag_type          tag_w   [0:NW];

   asc_front #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .src_valid  (req_ch.valid),
      .src_ready  (req_ch.ready),
      .src_op     (op_type'(req_ch.req_type)),
      .src_cmd    (req_ch.cmd_angle),
      .src_sys    (req_ch.sys_angle),
      .src_stop   (req_ch.stop_angle),
      .full_turn  (full_turn_ff),
      .scale_corr (scale_corr_ff),
      .dst_ready  (ready_w[0]),
      .dst_valid  (valid_w[0]),
      .dst_n      (n_w[0]),
      .dst_d      (d_w[0]),
      .dst_tag    (tag_w[0])
   );

   // division starts with empty remainder, quotient and residue
   assign r_w[0] = '0;
   assign q_w[0] = '0;
   assign m_w[0] = '0;

   for (genvar k = 0; k < NW; k++) begin : g_cell
      if (k < NW - 1) begin : g_mid
         asc_cell #(
            .NW (NW),
            .DW (DW),
            .QW (VW)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .src_valid (valid_w[k]),
            .src_ready (ready_w[k]),
            .src_n     (n_w[k]),
            .src_d     (d_w[k]),
            .src_r     (r_w[k]),
            .src_q     (q_w[k]),
            .src_m     (m_w[k]),
            .src_tag   (tag_w[k]),
            .dst_ready (ready_w[k+1]),
            .dst_valid (valid_w[k+1]),
            .dst_n     (n_w[k+1]),
            .dst_d     (d_w[k+1]),
            .dst_r     (r_w[k+1]),
            .dst_q     (q_w[k+1]),
            .dst_m     (m_w[k+1]),
            .dst_tag   (tag_w[k+1])
         );
      end else begin : g_last
         // dividend, divisor and remainder are spent after the last step
         asc_cell #(
            .NW (NW),
            .DW (DW),
            .QW (VW)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .src_valid (valid_w[k]),
            .src_ready (ready_w[k]),
            .src_n     (n_w[k]),
            .src_d     (d_w[k]),
            .src_r     (r_w[k]),
            .src_q     (q_w[k]),
            .src_m     (m_w[k]),
            .src_tag   (tag_w[k]),
            .dst_ready (ready_w[k+1]),
            .dst_valid (valid_w[k+1]),
            .dst_n     (),
            .dst_d     (),
            .dst_r     (),
            .dst_q     (q_w[k+1]),
            .dst_m     (m_w[k+1]),
            .dst_tag   (tag_w[k+1])
         );
      end
   end

   asc_back #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .src_valid  (valid_w[NW]),
      .src_ready  (ready_w[NW]),
      .src_q      (q_w[NW]),
      .src_m      (m_w[NW]),
      .src_tag    (tag_w[NW]),
      .full_turn  (full_turn_ff),
      .scale_corr (scale_corr_ff),
      .dst_ready  (rsp_ch.ready),
      .dst_valid  (rsp_ch.valid),
      .sys_result (rsp_ch.sys_result),
      .cmd_result (rsp_ch.cmd_result),
      .distance   (rsp_ch.distance)
   );

`ifndef SYNTHESIS
   // a free output frees every stage, so the input must be open
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("input stalled while output is free");

   // residue leaving the chain is a valid angle count
   a_residue_range: assert property (@(posedge clock) disable iff (reset)
      valid_w[NW] |-> (m_w[NW] < CMD_TURN))
      else $error("quotient residue out of range");

   // only the selected operation's field is non-zero
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ($countones({rsp_ch.sys_result != '0, rsp_ch.cmd_result != '0,
                                    rsp_ch.distance != '0}) <= 1))
      else $error("more than one result field set");

   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.cmd_result >= -16'sd23040 && rsp_ch.cmd_result <= 16'sd23039))
      else $error("command angle out of range");
`endif

endmodule
